@@ rtl/atd_pkg.sv @@
package atd_pkg;

  // Sample width used by the differencer; the port stays 16 bits wide
  localparam int SampleBits = 16;
  // Compare width: one bit above the wider of sample and threshold
  localparam int CmpBits    = 17;

  localparam int ThrBits    = 15;
  localparam int CountBits  = 8;
  localparam int CfgIdxBits = 2;
  localparam int CfgDataBits = 15;

  // Register reset values
  localparam logic [ThrBits-1:0]   EdgeThresholdReset = 15'd2880;
  localparam logic [CountBits-1:0] HoldPeriodReset    = 8'd90;
  localparam logic [CountBits-1:0] TapWindowReset     = 8'd10;

  // Configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_EDGE_THRESHOLD = 2'd0,
    CFG_HOLD_PERIOD    = 2'd1,
    CFG_TAP_WINDOW     = 2'd2
  } cfg_reg_t;

  // Current register settings
  typedef struct packed {
    logic [ThrBits-1:0]   edge_threshold;
    logic [CountBits-1:0] hold_period;
    logic [CountBits-1:0] tap_window;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic                 tap_seen;
    logic [CountBits-1:0] tap_total;
    logic                 holding;
  } result_t;

endpackage

@@ rtl/atd_cfg.sv @@
module atd_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [atd_pkg::CfgIdxBits-1:0]   cfg_index,
  input  logic [atd_pkg::CfgDataBits-1:0]  cfg_data,
  output atd_pkg::cfg_t                    cfg
);

  atd_pkg::cfg_t regs;

  // Register file; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.edge_threshold <= atd_pkg::EdgeThresholdReset;
      regs.hold_period    <= atd_pkg::HoldPeriodReset;
      regs.tap_window     <= atd_pkg::TapWindowReset;
    end else if (cfg_write) begin
      case (cfg_index)
        atd_pkg::CFG_EDGE_THRESHOLD: begin
          regs.edge_threshold <= cfg_data[atd_pkg::ThrBits-1:0];
        end
        atd_pkg::CFG_HOLD_PERIOD: begin
          regs.hold_period <= cfg_data[atd_pkg::CountBits-1:0];
        end
        atd_pkg::CFG_TAP_WINDOW: begin
          regs.tap_window <= cfg_data[atd_pkg::CountBits-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

@@ rtl/atd_core.sv @@
module atd_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [atd_pkg::SampleBits-1:0]   sample,
  input  atd_pkg::cfg_t                    cfg,
  output atd_pkg::result_t                 res_next
);

  localparam int SB = atd_pkg::SampleBits;
  localparam int CB = atd_pkg::CmpBits;
  localparam int NB = atd_pkg::CountBits;

  logic [SB-1:0] prev_sample;
  logic [NB-1:0] hold_count;
  logic          positive_first;
  logic [NB-1:0] tap_counter;

  logic [NB-1:0] hold_count_next;
  logic          positive_first_next;
  logic [NB-1:0] tap_counter_next;

  logic [SB-1:0]        diff;
  logic signed [CB-1:0] diff_s;
  logic signed [CB-1:0] thr_pos;
  logic signed [CB-1:0] thr_neg;
  logic                 pos_edge;
  logic                 neg_edge;
  logic [NB-1:0]        limit;
  logic [NB-1:0]        hold_mid;
  logic                 seen;

  // Wrapped difference, widened for signed compares against the threshold
  assign diff    = sample - prev_sample;
  assign diff_s  = signed'({{(CB-SB){diff[SB-1]}}, diff});
  assign thr_pos = signed'({{(CB-atd_pkg::ThrBits){1'b0}}, cfg.edge_threshold});
  assign thr_neg = -thr_pos;
  assign pos_edge = diff_s > thr_pos;
  assign neg_edge = diff_s < thr_neg;

  // Hold count at which the tap window closes
  assign limit = (cfg.hold_period > cfg.tap_window) ?
                 (cfg.hold_period - cfg.tap_window) : '0;

  // Next state: idle edge detection, or windowed opposite edge while holding
  always_comb begin
    hold_count_next     = hold_count;
    positive_first_next = positive_first;
    tap_counter_next    = tap_counter;
    hold_mid            = hold_count;
    seen                = 1'b0;
    if (hold_count != '0) begin
      if ((hold_count > limit) && (positive_first ? neg_edge : pos_edge)) begin
        tap_counter_next = tap_counter + NB'(1);
        seen             = 1'b1;
        hold_mid         = limit;
      end
      hold_count_next = (hold_mid != '0) ? (hold_mid - NB'(1)) : '0;
    end else if (pos_edge) begin
      positive_first_next = 1'b1;
      hold_count_next     = cfg.hold_period;
    end else if (neg_edge) begin
      positive_first_next = 1'b0;
      hold_count_next     = cfg.hold_period;
    end
  end

  // Result for the sample being taken
  always_comb begin
    res_next.tap_seen  = seen;
    res_next.tap_total = tap_counter_next;
    res_next.holding   = hold_count_next != '0;
  end

  // Detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample    <= '0;
      hold_count     <= '0;
      positive_first <= 1'b0;
      tap_counter    <= '0;
    end else if (step) begin
      prev_sample    <= sample;
      hold_count     <= hold_count_next;
      positive_first <= positive_first_next;
      tap_counter    <= tap_counter_next;
    end
  end

endmodule

@@ rtl/accel_tap_detector_unit.sv @@
// The input transfer loads the input register, and the result register loads from it
// once it is empty or being drained, so out_valid rises after both (2 register stages).
// Throughput: one sample per cycle while out_stall stays low; the single-pass detector
// logic between the two registers updates its state in the cycle it loads a result.
// Reset (rst, synchronous, active high) clears both pipeline valids, the detector
// state and the tap count, and returns the registers to 2880 / 90 / 10.
module accel_tap_detector_unit (
  input  logic                             clk,
  input  logic                             rst,
  // sample input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [15:0]               z_sample,
  // result output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             tap_seen,
  output logic [7:0]                       tap_total,
  output logic                             holding,
  // configuration
  input  logic                             cfg_write,
  input  logic [atd_pkg::CfgIdxBits-1:0]   cfg_index,
  input  logic [atd_pkg::CfgDataBits-1:0]  cfg_data
);

  logic                           s1_valid;
  logic [atd_pkg::SampleBits-1:0] s1_sample;
  logic                           step;
  logic                           in_xfer;
  atd_pkg::cfg_t                  cfg;
  atd_pkg::result_t               res_next;
  atd_pkg::result_t               res;

  // Handshake: result register loads when empty or being drained
  assign step     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !step;
  assign in_xfer  = in_valid && !in_stall;

  atd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  atd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .sample   (s1_sample),
    .cfg      (cfg),
    .res_next (res_next)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_sample <= z_sample[atd_pkg::SampleBits-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
    end
  end

  assign tap_seen  = res.tap_seen;
  assign tap_total = res.tap_total;
  assign holding   = res.holding;

  // Checks
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with empty input register");

  a_step_fills_output: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("result register not valid after load");

  a_item_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !step) |=> s1_valid)
    else $error("pending sample dropped");

  a_tap_counts: assert property (@(posedge clk) disable iff (rst)
    (step && res_next.tap_seen) |=> (tap_seen && tap_total == $past(res_next.tap_total)))
    else $error("tap pulse not delivered");

endmodule

@@ dv/accel_tap_checker.sv @@
module accel_tap_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [15:0]                     z_sample,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            tap_seen,
  input  logic [7:0]                      tap_total,
  input  logic                            holding,
  input  logic                            cfg_write,
  input  logic [atd_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [atd_pkg::CfgDataBits-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the registers and the detector state
  atd_pkg::cfg_t    regs;
  logic [15:0]      prev_z;
  logic [7:0]       hold_left;
  logic             pos_first;
  logic [7:0]       tap_cnt;

  // predicted results, oldest first
  atd_pkg::result_t expected_taps[$];

  initial fail_count = 0;
  initial pending = 0;

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] tap check: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // one sample through the detector: difference, edge test, hold countdown
  function automatic atd_pkg::result_t tap_step(logic [15:0] z);
    logic [15:0]      delta;
    int               d;
    int               thr;
    logic [7:0]       floor_cnt;
    atd_pkg::result_t r;
    delta  = z - prev_z;
    d      = int'($signed(delta));
    thr    = int'(regs.edge_threshold);
    prev_z = z;
    r.tap_seen = 1'b0;
    if (hold_left != 8'd0) begin
      floor_cnt = (regs.hold_period > regs.tap_window) ?
                  regs.hold_period - regs.tap_window : 8'd0;
      // still inside the early window: look for the opposite edge
      if (hold_left > floor_cnt) begin
        if (pos_first ? (d < -thr) : (d > thr)) begin
          tap_cnt    = tap_cnt + 8'd1;
          r.tap_seen = 1'b1;
          hold_left  = floor_cnt;
        end
      end
      if (hold_left != 8'd0) hold_left = hold_left - 8'd1;
    end else if (d > thr) begin
      pos_first = 1'b1;
      hold_left = regs.hold_period;
    end else if (d < -thr) begin
      pos_first = 1'b0;
      hold_left = regs.hold_period;
    end
    r.tap_total = tap_cnt;
    r.holding   = (hold_left != 8'd0);
    return r;
  endfunction

  always @(posedge clk) begin
    atd_pkg::result_t want;
    if (rst) begin
      regs.edge_threshold = atd_pkg::EdgeThresholdReset;
      regs.hold_period    = atd_pkg::HoldPeriodReset;
      regs.tap_window     = atd_pkg::TapWindowReset;
      prev_z    = '0;
      hold_left = '0;
      pos_first = 1'b0;
      tap_cnt   = '0;
      expected_taps.delete();
    end else begin
      if (cfg_write) begin
        case (atd_pkg::cfg_reg_t'(cfg_index))
          atd_pkg::CFG_EDGE_THRESHOLD: regs.edge_threshold = cfg_data;
          atd_pkg::CFG_HOLD_PERIOD:    regs.hold_period    = cfg_data[7:0];
          atd_pkg::CFG_TAP_WINDOW:     regs.tap_window     = cfg_data[7:0];
          default: ;
        endcase
      end
      // result transfer: compare with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_taps.size() == 0) begin
          report_mismatch("result with none pending, tap_total", int'(tap_total), -1);
        end else begin
          want = expected_taps.pop_front();
          if (tap_seen !== want.tap_seen)
            report_mismatch("tap_seen", int'(tap_seen), int'(want.tap_seen));
          if (tap_total !== want.tap_total)
            report_mismatch("tap_total", int'(tap_total), int'(want.tap_total));
          if (holding !== want.holding)
            report_mismatch("holding", int'(holding), int'(want.holding));
        end
      end
      // sample transfer: predict its result
      if (in_valid && !in_stall) expected_taps.push_back(tap_step(z_sample));
    end
    pending = expected_taps.size();
  end

endmodule

@@ dv/tb_accel_tap_detector_unit.sv @@
module tb_accel_tap_detector_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemsPerPhase = 145;
  localparam int NumPhases     = 10;
  localparam int HoldOffCycles = 250;
  localparam int CycleLimit    = 400000;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  logic signed [15:0]              z_sample  = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            tap_seen;
  logic [7:0]                      tap_total;
  logic                            holding;
  logic                            cfg_write = 1'b0;
  logic [atd_pkg::CfgIdxBits-1:0]  cfg_index = atd_pkg::CFG_EDGE_THRESHOLD;
  logic [atd_pkg::CfgDataBits-1:0] cfg_data  = '0;

  int                     fail_count;
  int                     pending;

  // stimulus state
  logic [15:0]            level   = '0;
  logic                   last_up = 1'b0;
  int                     cur_thr = int'(atd_pkg::EdgeThresholdReset);
  int                     calm_left = 0;
  bit                     hold_off_req = 1'b0;

  always #5 clk = ~clk;

  accel_tap_detector_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .z_sample  (z_sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tap_seen  (tap_seen),
    .tap_total (tap_total),
    .holding   (holding),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  accel_tap_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .z_sample   (z_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tap_seen   (tap_seen),
    .tap_total  (tap_total),
    .holding    (holding),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // sender gap: mostly none or short, a few long, with calm stretches
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // next sample: quiet drift, edges of either sign, opposite edges, or noise
  function automatic logic [15:0] next_level();
    int r;
    int m;
    int s;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      s     = cur_thr / 2;
      m     = int'($urandom_range(0, 2 * s)) - s;
      level = level + 16'(m);
    end else if (r < 90) begin
      m = cur_thr + 1 + int'($urandom_range(0, 1500));
      if (m > 32768) m = 32768;
      if (r < 72) last_up = 1'($urandom_range(0, 1));
      else last_up = ~last_up;
      level = last_up ? level + 16'(m) : level - 16'(m);
    end else begin
      level = 16'($urandom);
    end
    return level;
  endfunction

  // offer one sample and wait for its transfer
  task automatic push_sample(logic [15:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    z_sample <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and let every pending result come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // write all three registers back to back
  task automatic set_config(int thr, int hold_len, int win);
    cfg_write <= 1'b1;
    cfg_index <= atd_pkg::CFG_EDGE_THRESHOLD;
    cfg_data  <= atd_pkg::CfgDataBits'(thr);
    @(posedge clk);
    cfg_index <= atd_pkg::CFG_HOLD_PERIOD;
    cfg_data  <= atd_pkg::CfgDataBits'(hold_len);
    @(posedge clk);
    cfg_index <= atd_pkg::CFG_TAP_WINDOW;
    cfg_data  <= atd_pkg::CfgDataBits'(win);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_thr = thr;
  endtask

  task automatic run_random(int n, int hold_off_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_off_at) hold_off_req = 1'b1;
      push_sample(next_level());
    end
  endtask

  // receiver: random stall runs, with one long hold-off on request
  initial begin
    int r;
    int n;
    wait (!rst);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 8);
        end else if (r < 85) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else if (r < 95) begin
          out_stall <= 1'b0;
          n = $urandom_range(20, 60);
        end else begin
          out_stall <= 1'b1;
          n = $urandom_range(10, 30);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  // watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // main sequence
  initial begin
    logic [15:0] opening [11];
    opening = '{16'd0, 16'd2881, 16'd2881, 16'd1, 16'd0, 16'hF4BF,
                16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'd0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: positive-first tap, a near miss at the threshold,
    // the opposite edge, and the sample extremes with wrapped differences
    foreach (opening[i]) push_sample(opening[i]);
    level = opening[10];
    run_random(ItemsPerPhase, 30);

    for (int ph = 1; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        1:       set_config(0, 1, 0);          // zero threshold, shortest hold
        2:       set_config(32767, 255, 254);  // all-ones threshold and hold, window one below
        3:       set_config(1000, 0, 3);       // zero hold period
        4:       set_config(800, 4, 7);        // window not below hold
        5:       set_config(1500, 12, 5);
        default: set_config($urandom_range(0, 4000), $urandom_range(0, 40),
                            $urandom_range(0, 15));
      endcase
      run_random(ItemsPerPhase, -1);
    end
    drain();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
